>>> rtl/dpf_pkg.sv
// Package: shared types and constants for the dedup packet FIFO.
`default_nettype none
package dpf_pkg;

   // field widths
   localparam int SRC_W    = 16;
   localparam int DST_W    = 16;
   localparam int TIME_W   = 30;
   localparam int LIMIT_W  = 9;
   localparam int COUNT_W  = 9;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // request codes
   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_FWD   = 2'd1;
   localparam logic [1:0] REQ_COUNT = 2'd2;

   // register indexes (word index taken from the byte address)
   localparam logic CSR_QUEUE_LIMIT = 1'b0;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 9'd511;

   // one queued packet
   typedef struct packed {
      logic [SRC_W-1:0]  src;
      logic [DST_W-1:0]  dst;
      logic [TIME_W-1:0] tstamp;
   } entry_type;

   // request broadcast to every cell
   typedef struct packed {
      logic              is_add;
      logic [SRC_W-1:0]  src;
      logic [DST_W-1:0]  dst;
      logic [TIME_W-1:0] tstamp;
      logic [TIME_W-1:0] win_lo;
      logic [TIME_W-1:0] win_hi;
   } query_type;

   // update strobes for the cell chain
   typedef struct packed {
      logic add_commit;
      logic pop_commit;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_APPLY
   } state_type;

endpackage
`default_nettype wire

>>> rtl/dpf_if.sv
// Interfaces: request and response channels of the dedup packet FIFO.
`default_nettype none
interface dpf_req_if import dpf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic [SRC_W-1:0]  pkt_source;
   logic [DST_W-1:0]  pkt_dest;
   logic [TIME_W-1:0] pkt_time;
   logic [TIME_W-1:0] window_start;
   logic [TIME_W-1:0] window_end;

   modport source (output valid, req_type, pkt_source, pkt_dest, pkt_time,
                   window_start, window_end, input ready);
   modport sink   (input valid, req_type, pkt_source, pkt_dest, pkt_time,
                   window_start, window_end, output ready);
endinterface

interface dpf_rsp_if import dpf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               add_accepted;
   logic               fwd_valid;
   logic [SRC_W-1:0]   fwd_source;
   logic [DST_W-1:0]   fwd_dest;
   logic [TIME_W-1:0]  fwd_time;
   logic [COUNT_W-1:0] match_count;

   modport source (output valid, add_accepted, fwd_valid, fwd_source, fwd_dest,
                   fwd_time, match_count, input ready);
   modport sink   (input valid, add_accepted, fwd_valid, fwd_source, fwd_dest,
                   fwd_time, match_count, output ready);
endinterface
`default_nettype wire

>>> rtl/dpf_cell.sv
// Cell: one queue slot with its match compare and shift toward the head.
`default_nettype none
module dpf_cell import dpf_pkg::*; #(
   parameter int OW  = 9,
   parameter int IDX = 0
) (
   input  wire logic         clock,
   input  wire query_type    query_i,
   input  wire cell_ctl_type ctl_i,
   input  wire logic [OW-1:0] occ_i,
   input  wire logic [OW-1:0] wr_pos_i,
   input  wire entry_type    nbr_i,
   output entry_type         entry_o,
   output logic              match_o
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      slot_used;
   logic      eq_all;
   logic      in_win;
   logic      load;

   // slot is live when it sits below the fill level
   assign slot_used = occ_i > OW'(IDX);

   // duplicate compare and window compare
   assign eq_all = (entry_ff.src == query_i.src) && (entry_ff.dst == query_i.dst) &&
                   (entry_ff.tstamp == query_i.tstamp);
   assign in_win = (entry_ff.dst == query_i.dst) && (entry_ff.tstamp >= query_i.win_lo) &&
                   (entry_ff.tstamp <= query_i.win_hi);
   assign match_o = slot_used && (query_i.is_add ? eq_all : in_win);

   assign load = ctl_i.add_commit && (wr_pos_i == OW'(IDX));

   // new packet lands here, else take the neighbor's on a pop
   always_comb begin
      priority if (load) begin
         entry_in.src    = query_i.src;
         entry_in.dst    = query_i.dst;
         entry_in.tstamp = query_i.tstamp;
      end else if (ctl_i.pop_commit) begin
         entry_in = nbr_i;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_o = entry_ff;

endmodule
`default_nettype wire

>>> rtl/dpf_tree.sv
// Tree: registered adder tree counting the match bits of all cells.
`default_nettype none
module dpf_tree #(
   parameter int LEAVES = 256,
   parameter int CW     = 9
) (
   input  wire logic              clock,
   input  wire logic [LEAVES-1:0] leaf_i,
   output logic [CW-1:0]          sum_o
);

   localparam int LV    = $clog2(LEAVES);
   localparam int PAD   = 1 << LV;
   localparam int NODES = 2 * PAD - 1;

   // heap layout: node n has children 2n+1 and 2n+2, leaves at the end
   logic [CW-1:0] node_ff [NODES];
   logic [CW-1:0] node_in [NODES];

   genvar k;
   generate
      for (k = 0; k < PAD; k++) begin : g_leaf
         if (k < LEAVES) begin : g_real
            assign node_in[PAD-1+k] = CW'(leaf_i[k]);
         end else begin : g_pad
            assign node_in[PAD-1+k] = '0;
         end
      end
      for (k = 0; k < PAD - 1; k++) begin : g_node
         assign node_in[k] = node_ff[2*k+1] + node_ff[2*k+2];
      end
   endgenerate

   // every tree level is registered
   always_ff @(posedge clock) begin
      for (int n = 0; n < NODES; n++) begin
         node_ff[n] <= node_in[n];
      end
   end

   assign sum_o = node_ff[0];

endmodule
`default_nettype wire

>>> rtl/dedup_packet_fifo_with_range_count_core.sv
// Top level: bounded packet FIFO with duplicate filter and window count.
//
// Requests arrive on req_chan (valid/ready); req_type selects add packet,
// forward oldest, or count packets for a destination in a time window.
// Every request gives exactly one response on rsp_chan; fields a request
// does not produce read as zero, and request code 3 gives an all-zero item.
// The queue is a chain of QUEUE_DEPTH cells, oldest packet in cell 0; a pop
// moves every cell's packet one place toward the head.
// Every cell compares its packet against the request in parallel; the match
// bits are summed by a registered adder tree with a register on every node.
// A new request is taken only after the previous one has been applied, as
// req_chan.ready is high only in the idle state; the tree depth sets how
// long the sequencer waits in its sum step.
// The response sits in an output register; a stalled receiver holds it, and
// the next response waits in the apply step until that register frees.
// queue_limit (csr byte address 0, reset 256) bounds the fill level; an add
// at the limit drops the oldest packet first. 0 acts as 1, values above
// QUEUE_DEPTH as QUEUE_DEPTH. Write it only while the block is idle.
// Synchronous reset empties the queue and restores the limit.
`default_nettype none
module dedup_packet_fifo_with_range_count_core import dpf_pkg::*; #(
   parameter int QUEUE_DEPTH = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   dpf_req_if.sink                req_chan,
   dpf_rsp_if.source              rsp_chan,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   localparam int OW  = $clog2(QUEUE_DEPTH + 1);
   localparam int LV  = $clog2(QUEUE_DEPTH);
   localparam int TW  = $clog2(LV + 1);

   state_type          state_ff, state_in;
   logic [TW-1:0]      wait_ff, wait_in;
   query_type          query_ff, query_in;
   logic [1:0]         kind_ff, kind_in;
   logic [OW-1:0]      occ_ff, occ_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               add_acc_ff, add_acc_in;
   logic               fwd_valid_ff, fwd_valid_in;
   entry_type          fwd_ff, fwd_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic                   req_fire;
   logic                   csr_write;
   logic                   out_free;
   logic                   do_apply;
   logic [31:0]            eff_limit;
   logic                   occ_full;
   logic [OW-1:0]          wr_pos;
   cell_ctl_type           cell_ctl;
   logic [QUEUE_DEPTH-1:0] match_bits;
   entry_type              cell_entry [QUEUE_DEPTH];
   logic [OW-1:0]          hits;
   logic [31:0]            hits_ext;
   logic                   no_dup;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   // config register port
   assign csr_pready = 1'b1;
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_QUEUE_LIMIT) begin
         csr_prdata = CSR_DW'(limit_ff);
      end
   end

   always_comb begin
      limit_in = limit_ff;
      if (csr_write && (csr_paddr[2] == CSR_QUEUE_LIMIT)) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   // effective limit: zero acts as one, clamp to depth
   always_comb begin
      priority if (limit_ff == '0) begin
         eff_limit = 32'd1;
      end else if (32'(limit_ff) > 32'(QUEUE_DEPTH)) begin
         eff_limit = 32'(QUEUE_DEPTH);
      end else begin
         eff_limit = 32'(limit_ff);
      end
   end
   assign occ_full = 32'(occ_ff) >= eff_limit;
   assign wr_pos   = occ_full ? occ_ff - OW'(1) : occ_ff;

   // cell chain
   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         entry_type nbr;
         if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign nbr = '0;
         end else begin : g_mid
            assign nbr = cell_entry[g+1];
         end
         dpf_cell #(
            .OW  (OW),
            .IDX (g)
         ) u_cell (
            .clock    (clock),
            .query_i  (query_ff),
            .ctl_i    (cell_ctl),
            .occ_i    (occ_ff),
            .wr_pos_i (wr_pos),
            .nbr_i    (nbr),
            .entry_o  (cell_entry[g]),
            .match_o  (match_bits[g])
         );
      end
   endgenerate

   dpf_tree #(
      .LEAVES (QUEUE_DEPTH),
      .CW     (OW)
   ) u_tree (
      .clock  (clock),
      .leaf_i (match_bits),
      .sum_o  (hits)
   );

   assign hits_ext = 32'(hits);
   assign no_dup   = (hits == '0);
   assign do_apply = (state_ff == ST_APPLY) && out_free;

   // chain update strobes, only in the apply step
   always_comb begin
      cell_ctl.add_commit = do_apply && (kind_ff == REQ_ADD) && no_dup;
      cell_ctl.pop_commit = do_apply && (((kind_ff == REQ_ADD) && no_dup && occ_full) ||
                                         ((kind_ff == REQ_FWD) && (occ_ff != '0)));
   end

   always_comb begin
      occ_in = occ_ff;
      if (cell_ctl.add_commit && !cell_ctl.pop_commit) begin
         occ_in = occ_ff + OW'(1);
      end else if (cell_ctl.pop_commit && !cell_ctl.add_commit) begin
         occ_in = occ_ff - OW'(1);
      end
   end

   // sequencer: capture, wait for the tree, apply
   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      query_in = query_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               query_in.is_add = (req_chan.req_type == REQ_ADD);
               query_in.src    = req_chan.pkt_source;
               query_in.dst    = req_chan.pkt_dest;
               query_in.tstamp = req_chan.pkt_time;
               query_in.win_lo = req_chan.window_start;
               query_in.win_hi = req_chan.window_end;
               kind_in  = req_chan.req_type;
               wait_in  = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            wait_in = wait_ff + TW'(1);
            if (wait_ff == TW'(LV)) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      add_acc_in   = add_acc_ff;
      fwd_valid_in = fwd_valid_ff;
      fwd_in       = fwd_ff;
      count_in     = count_ff;
      if (do_apply) begin
         rsp_valid_in = 1'b1;
         add_acc_in   = 1'b0;
         fwd_valid_in = 1'b0;
         fwd_in       = '0;
         count_in     = '0;
         unique case (kind_ff)
            REQ_ADD: begin
               add_acc_in = no_dup;
            end
            REQ_FWD: begin
               if (occ_ff != '0) begin
                  fwd_valid_in = 1'b1;
                  fwd_in       = cell_entry[0];
               end
            end
            REQ_COUNT: begin
               count_in = (hits_ext > 32'(COUNT_MAX)) ? COUNT_MAX : hits_ext[COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= '0;
         occ_ff       <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         occ_ff       <= occ_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff     <= query_in;
      kind_ff      <= kind_in;
      add_acc_ff   <= add_acc_in;
      fwd_valid_ff <= fwd_valid_in;
      fwd_ff       <= fwd_in;
      count_ff     <= count_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.add_accepted = add_acc_ff;
   assign rsp_chan.fwd_valid    = fwd_valid_ff;
   assign rsp_chan.fwd_source   = fwd_ff.src;
   assign rsp_chan.fwd_dest     = fwd_ff.dst;
   assign rsp_chan.fwd_time     = fwd_ff.tstamp;
   assign rsp_chan.match_count  = count_ff;

endmodule
`default_nettype wire
